FILE: sv/hdg_pkg.sv
// ----------------------------------------------------------------------------
// hdg_pkg - shared types and constants of the heading pipeline
// Fixed-point formats, the arctangent table and the word that moves from one
// CORDIC cell to the next.
// ----------------------------------------------------------------------------
package hdg_pkg;

  // CORDIC depth and angle scale (degrees * 2^ANGLE_FRAC_BITS)
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int IDX_W           = 4;

  // Vector width: 17-bit folded reading scaled by 2^CORDIC_STEPS plus gain headroom
  localparam int XY_W = 36;
  // Angle width: holds +-280 deg of CORDIC output plus a 511 deg offset
  localparam int Z_W  = 28;

  localparam int RD_W  = 16;
  localparam int OFF_W = 9;
  localparam int HDG_W = 9;

  localparam logic [OFF_W-1:0] OFFSET_RESET = 9'd96;

  localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0] Z_180 = Z_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0] Z_360 = Z_W'(360 * (1 << ANGLE_FRAC_BITS));

  // Word handed along the cell chain
  typedef struct packed {
    logic                  byp;  // axis input: angle already exact, skip rotation
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } hdg_vec_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:    v = 28'sd2949120;
      4'd1:    v = 28'sd1740967;
      4'd2:    v = 28'sd919879;
      4'd3:    v = 28'sd466945;
      4'd4:    v = 28'sd234379;
      4'd5:    v = 28'sd117304;
      4'd6:    v = 28'sd58666;
      4'd7:    v = 28'sd29335;
      4'd8:    v = 28'sd14668;
      4'd9:    v = 28'sd7334;
      4'd10:   v = 28'sd3667;
      4'd11:   v = 28'sd1833;
      4'd12:   v = 28'sd917;
      4'd13:   v = 28'sd458;
      4'd14:   v = 28'sd229;
      4'd15:   v = 28'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/hdg_prep.sv
// ----------------------------------------------------------------------------
// hdg_prep - quadrant fold and axis detection
// Folds the reading into the right half plane, sets the start angle and
// flags readings on an axis, whose angle is exact and skips the rotation.
// ----------------------------------------------------------------------------
module hdg_prep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic signed [hdg_pkg::RD_W-1:0]      x_i,
  input  logic signed [hdg_pkg::RD_W-1:0]      y_i,
  output logic                                 vld_o,
  output hdg_pkg::hdg_vec_t                    vec_o
);

  localparam int FW  = hdg_pkg::RD_W + 1;
  localparam int PAD = hdg_pkg::XY_W - FW - hdg_pkg::CORDIC_STEPS;

  logic                     vld_r;
  hdg_pkg::hdg_vec_t        vec_r;
  hdg_pkg::hdg_vec_t        vec_nxt;
  logic signed [FW-1:0]     xe;
  logic signed [FW-1:0]     ye;
  logic signed [FW-1:0]     xf;
  logic signed [FW-1:0]     yf;
  logic                     x_zero;
  logic                     y_zero;

  // fold, start angle and axis bypass
  always_comb begin
    xe     = {x_i[hdg_pkg::RD_W-1], x_i};
    ye     = {y_i[hdg_pkg::RD_W-1], y_i};
    x_zero = (x_i == '0);
    y_zero = (y_i == '0);
    xf     = x_i[hdg_pkg::RD_W-1] ? -xe : xe;
    yf     = x_i[hdg_pkg::RD_W-1] ? -ye : ye;

    vec_nxt.byp = x_zero || y_zero;
    vec_nxt.x   = {{PAD{xf[FW-1]}}, xf, {hdg_pkg::CORDIC_STEPS{1'b0}}};
    vec_nxt.y   = {{PAD{yf[FW-1]}}, yf, {hdg_pkg::CORDIC_STEPS{1'b0}}};

    priority if (y_zero) begin
      vec_nxt.z = x_i[hdg_pkg::RD_W-1] ? hdg_pkg::Z_180 : '0;
    end else if (x_zero) begin
      vec_nxt.z = y_i[hdg_pkg::RD_W-1] ? -hdg_pkg::Z_90 : hdg_pkg::Z_90;
    end else if (x_i[hdg_pkg::RD_W-1]) begin
      vec_nxt.z = y_i[hdg_pkg::RD_W-1] ? -hdg_pkg::Z_180 : hdg_pkg::Z_180;
    end else begin
      vec_nxt.z = '0;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;

endmodule

FILE: sv/hdg_cell.sv
// ----------------------------------------------------------------------------
// hdg_cell - one CORDIC vectoring iteration
// Rotates the vector toward the X axis by atan(2^-STEP) and accumulates the
// angle, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module hdg_cell #(
  parameter logic [hdg_pkg::IDX_W-1:0] STEP = 4'd0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  hdg_pkg::hdg_vec_t vec_i,
  output logic              vld_o,
  output hdg_pkg::hdg_vec_t vec_o
);

  localparam logic signed [hdg_pkg::Z_W-1:0] ROM = hdg_pkg::atan_deg(STEP);

  logic                              vld_r;
  hdg_pkg::hdg_vec_t                 vec_r;
  hdg_pkg::hdg_vec_t                 vec_nxt;
  logic signed [hdg_pkg::XY_W-1:0]   x_s;
  logic signed [hdg_pkg::XY_W-1:0]   y_s;
  logic signed [hdg_pkg::XY_W-1:0]   dx;
  logic signed [hdg_pkg::XY_W-1:0]   dy;

  // rotate by the sign of y; axis words pass unchanged
  always_comb begin
    x_s     = vec_i.x;
    y_s     = vec_i.y;
    dx      = y_s >>> STEP;
    dy      = x_s >>> STEP;
    vec_nxt = vec_i;
    if (!vec_i.byp) begin
      if (!y_s[hdg_pkg::XY_W-1]) begin
        vec_nxt.x = x_s + dx;
        vec_nxt.y = y_s - dy;
        vec_nxt.z = vec_i.z + ROM;
      end else begin
        vec_nxt.x = x_s - dx;
        vec_nxt.y = y_s + dy;
        vec_nxt.z = vec_i.z - ROM;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;

endmodule

FILE: sv/hdg_post.sv
// ----------------------------------------------------------------------------
// hdg_post - offset, wrap, mirror and output register
// Adds the mounting offset, corrects the sum by 360 once toward 0..360,
// mirrors to 360 minus the angle, clamps below 0 and keeps whole degrees.
// ----------------------------------------------------------------------------
module hdg_post (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  logic signed [hdg_pkg::Z_W-1:0]  z_i,
  input  logic [hdg_pkg::OFF_W-1:0]       offset_i,
  output logic                            vld_o,
  output logic [hdg_pkg::HDG_W-1:0]       heading_o
);

  localparam int F   = hdg_pkg::ANGLE_FRAC_BITS;
  localparam int OPD = hdg_pkg::Z_W - hdg_pkg::OFF_W - F;

  logic                            vld_r;
  logic [hdg_pkg::HDG_W-1:0]       heading_r;
  logic [hdg_pkg::HDG_W-1:0]       heading_nxt;
  logic signed [hdg_pkg::Z_W-1:0]  off_z;
  logic signed [hdg_pkg::Z_W-1:0]  sum;
  logic signed [hdg_pkg::Z_W-1:0]  wrapped;
  logic signed [hdg_pkg::Z_W-1:0]  mirrored;

  // add offset, wrap once, mirror, clamp and truncate
  always_comb begin
    off_z = {{OPD{1'b0}}, offset_i, {F{1'b0}}};
    sum   = z_i + off_z;
    priority if (sum > hdg_pkg::Z_360) begin
      wrapped = sum - hdg_pkg::Z_360;
    end else if (sum < 0) begin
      wrapped = sum + hdg_pkg::Z_360;
    end else begin
      wrapped = sum;
    end
    mirrored    = hdg_pkg::Z_360 - wrapped;
    heading_nxt = mirrored[hdg_pkg::Z_W-1] ? '0 : mirrored[F+hdg_pkg::HDG_W-1:F];
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (en) begin
      heading_r <= heading_nxt;
    end
  end

  assign vld_o     = vld_r;
  assign heading_o = heading_r;

endmodule

FILE: sv/magnetometer_heading.sv
// Pipeline from an accepted input word to its result word: fold stage,
// 16 CORDIC iteration cells, output register.
// Throughput: one word per cycle; the whole cell chain advances together and
// holds while the output register holds a word that is not taken.
// Reset (synchronous, rst_n low): clears every valid bit, offset becomes 96.
// ----------------------------------------------------------------------------
// magnetometer_heading - compass heading from X/Y field readings
// Pipelined CORDIC atan2 in degrees, mounting offset, wrap and mirror.
// ----------------------------------------------------------------------------
module magnetometer_heading (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_reading, [31:16] y_reading
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [8:0] heading_deg, [15:9] zero
  // offset register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // mount_offset_deg
);

  localparam int NS = hdg_pkg::CORDIC_STEPS;
  localparam int IW = hdg_pkg::IDX_W;

  logic                          en;
  logic [hdg_pkg::OFF_W-1:0]     offset_r;
  logic                          vld_w [0:NS];
  hdg_pkg::hdg_vec_t             vec_w [0:NS];
  logic [hdg_pkg::HDG_W-1:0]     heading;

  // advance the chain when the output word is empty or taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // mounting offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= hdg_pkg::OFFSET_RESET;
    end else if (cfg_valid) begin
      offset_r <= cfg_data;
    end
  end

  hdg_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .x_i   (in_tdata[15:0]),
    .y_i   (in_tdata[31:16]),
    .vld_o (vld_w[0]),
    .vec_o (vec_w[0])
  );

  // one cell per iteration
  for (genvar g = 0; g < NS; g++) begin : g_cell
    hdg_cell #(
      .STEP (IW'(g))
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_w[g]),
      .vec_i (vec_w[g]),
      .vld_o (vld_w[g+1]),
      .vec_o (vec_w[g+1])
    );
  end

  hdg_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (vld_w[NS]),
    .z_i       (vec_w[NS].z),
    .offset_i  (offset_r),
    .vld_o     (out_tvalid),
    .heading_o (heading)
  );

  assign out_tdata = {7'd0, heading};

endmodule

FILE: sv/hdg_checker.sv
// ----------------------------------------------------------------------------
// hdg_checker - port-level checks of the heading pipeline
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module hdg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word dropped or changed");

  // accept input exactly when the output register is free or drains
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // heading stays within 0..360 with zero padding
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'd0) && (out_tdata[8:0] <= 9'd360))
    else $error("heading out of range");

  // no result word right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind magnetometer_heading hdg_checker u_hdg_checker (.*);

FILE: tb/sv/magnetometer_heading_tb.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_tb - self-checking bench for the compass heading block
// Streams X/Y readings through the block, predicts each heading with an
// independent CORDIC atan2 model, and checks every result word in order.
// It covers several offset settings, random sender gaps, receiver stalls,
// and a long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module magnetometer_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 180;
  localparam int FRAC         = hdg_pkg::ANGLE_FRAC_BITS;
  localparam int STEPS        = hdg_pkg::CORDIC_STEPS;
  localparam int RD_W         = hdg_pkg::RD_W;
  localparam int HDG_W        = hdg_pkg::HDG_W;
  localparam int OFF_W        = hdg_pkg::OFF_W;
  localparam int RAD_SCALE    = 58;

  typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  typedef struct {
    logic signed [RD_W-1:0] x;
    logic signed [RD_W-1:0] y;
    logic [HDG_W-1:0]       heading;
  } heading_exp_t;

  // Predicts headings from readings and checks result words in order
  class heading_predictor;
    longint           atan_tbl[STEPS];
    logic [OFF_W-1:0] offset_deg;
    heading_exp_t     expected_headings[$];
    int               errors;

    function new();
      longint unsigned quarter_pi, num, q, r;
      quarter_pi = 4 * atan_inv(5) - atan_inv(239);
      atan_tbl[0] = 45 * (64'sd1 <<< FRAC);
      for (int i = 1; i < STEPS; i++) begin
        num = atan_inv(64'd1 << i) * 45;
        q = num / quarter_pi;
        r = num % quarter_pi;
        // long division for FRAC+1 more bits, then round to nearest
        for (int b = 0; b <= FRAC; b++) begin
          r = r << 1;
          q = q << 1;
          if (r >= quarter_pi) begin
            r = r - quarter_pi;
            q = q | 1;
          end
        end
        atan_tbl[i] = longint'((q + 1) >> 1);
      end
      offset_deg = hdg_pkg::OFFSET_RESET;
      errors = 0;
    endfunction

    // atan(1/n) in radians at 2^RAD_SCALE, Taylor series
    static function longint unsigned atan_inv(longint unsigned n);
      longint unsigned p, nn, acc, term, k;
      p = (64'd1 << RAD_SCALE) / n;
      nn = n * n;
      acc = 0;
      k = 0;
      while (p != 0) begin
        term = p / (2 * k + 1);
        if (k[0] == 1'b0) acc = acc + term;
        else acc = acc - term;
        p = p / nn;
        k++;
      end
      return acc;
    endfunction

    // atan2(y, x) in degrees at 2^FRAC
    function longint angle_fx(longint x, longint y);
      longint one, z, dx, dy;
      one = 64'sd1 <<< FRAC;
      z = 0;
      if (y == 0) return (x < 0) ? 180 * one : 0;
      if (x == 0) return (y > 0) ? 90 * one : -90 * one;
      // fold the left half plane onto the right
      if (x < 0) begin
        z = (y >= 0) ? 180 * one : -180 * one;
        x = -x;
        y = -y;
      end
      x = x <<< STEPS;
      y = y <<< STEPS;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_tbl[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_tbl[i];
        end
      end
      return z;
    endfunction

    function void note_reading(logic signed [RD_W-1:0] x, logic signed [RD_W-1:0] y);
      longint       one, angle, mirrored;
      heading_exp_t e;
      one = 64'sd1 <<< FRAC;
      angle = angle_fx(longint'(x), longint'(y)) + longint'(offset_deg) * one;
      // single wrap correction; exactly 360 is kept
      if (angle > 360 * one) angle = angle - 360 * one;
      else if (angle < 0) angle = angle + 360 * one;
      mirrored = 360 * one - angle;
      if (mirrored < 0) mirrored = 0;
      e.x = x;
      e.y = y;
      e.heading = HDG_W'(mirrored >>> FRAC);
      expected_headings.push_back(e);
    endfunction

    function void check_heading(logic [HDG_W-1:0] heading);
      heading_exp_t e;
      if (expected_headings.size() == 0) begin
        $display("%0t unexpected result word: expected none, actual heading %0d",
                 $time, heading);
        errors++;
        return;
      end
      e = expected_headings.pop_front();
      if (heading !== e.heading) begin
        $display("%0t heading mismatch (x=%0d y=%0d): expected %0d, actual %0d",
                 $time, e.x, e.y, e.heading, heading);
        errors++;
      end
    endfunction

    function int pending();
      return expected_headings.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [OFF_W-1:0]  cfg_data;

  heading_predictor hdg = new();
  int               hold_requests = 0;
  int               burst_left = 0;

  magnetometer_heading i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one reading word, hold until accepted, then maybe open a gap
  task automatic send_reading(logic signed [RD_W-1:0] x, logic signed [RD_W-1:0] y);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    hdg.note_reading(x, y);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold until every expected heading has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hdg.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(logic [OFF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdg.offset_deg = value;
  endtask

  function automatic logic signed [RD_W-1:0] pick_reading();
    logic signed [RD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'sd0;
          1: v = 16'sd1;
          2: v = -16'sd1;
          3: v = 16'sh7fff;
          default: v = 16'sh8000;
        endcase
      end
      1, 2: v = RD_W'($urandom_range(0, 128)) - 16'sd64;
      default: v = RD_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_phase(logic [OFF_W-1:0] offset, bit with_hold);
    write_offset(offset);
    // long receiver hold-off while readings keep coming
    if (with_hold) hold_requests++;
    for (int n = 0; n < PHASE_ITEMS; n++) send_reading(pick_reading(), pick_reading());
    wait_drained();
  endtask

  // Receiver: check each taken word, then choose the next ready level
  initial begin
    int       hold_left;
    int       seen_holds;
    int       mode_left;
    rx_mode_t rx_mode;
    hold_left  = 0;
    seen_holds = 0;
    mode_left  = 0;
    rx_mode    = RX_STREAM;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) hdg.check_heading(out_tdata[HDG_W-1:0]);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM: out_tready <= 1'b1;
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: origin, axes, full-scale corners, left-half fold both ways
    send_reading(16'sd0, 16'sd0);
    send_reading(16'sd1, 16'sd0);
    send_reading(-16'sd1, 16'sd0);
    send_reading(16'sd0, 16'sd1);
    send_reading(16'sd0, -16'sd1);
    send_reading(16'sh7fff, 16'sd0);
    send_reading(16'sh8000, 16'sd0);
    send_reading(16'sd0, 16'sh7fff);
    send_reading(16'sd0, 16'sh8000);
    send_reading(16'sh7fff, 16'sh7fff);
    send_reading(16'sh8000, 16'sh8000);
    send_reading(16'sh8000, 16'sh7fff);
    send_reading(16'sh7fff, 16'sh8000);
    send_reading(16'sd1, 16'sd1);
    send_reading(-16'sd1, 16'sd1);
    send_reading(-16'sd1, -16'sd1);
    send_reading(16'sd1, -16'sd1);
    send_reading(16'sh8000, -16'sd1);
    send_reading(16'sh8000, 16'sd1);
    send_reading(16'sd100, -16'sd1);
    send_reading(16'sd5, 16'sd12);
    wait_drained();

    // Random phases over offset extremes, out-of-range values and random ones
    random_phase(9'd0, 1'b1);
    random_phase(9'd359, 1'b0);
    random_phase(9'd511, 1'b1);
    random_phase(9'd360, 1'b0);
    random_phase(9'd1, 1'b0);
    random_phase(OFF_W'($urandom_range(0, 359)), 1'b1);
    random_phase(OFF_W'($urandom_range(0, 511)), 1'b0);
    random_phase(OFF_W'($urandom_range(0, 359)), 1'b0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (hdg.errors == 0 && hdg.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/hdg_pkg.sv
sv/hdg_prep.sv
sv/hdg_cell.sv
sv/hdg_post.sv
sv/magnetometer_heading.sv
sv/hdg_checker.sv
tb/sv/magnetometer_heading_tb.sv
